[src/crd_pkg.sv]
// shared constants and types for the camera ray direction unit
package crd_pkg;

  // fixed-point one in q2.14
  localparam int ONE_Q14 = 16384;

  // normalizer internals
  localparam int MAG_W  = 30;            // magnitude width after pre-shift
  localparam int SQ_W   = 2 * MAG_W;     // one squared component
  localparam int ROOT_W = MAG_W + 1;     // integer square root of the sum
  localparam int SUM_W  = 2 * ROOT_W;    // sum of three squares
  localparam int REM_W  = ROOT_W + 1;    // sqrt partial remainder
  localparam int FRAC_W = 14;            // q14 scaling of the quotient
  localparam int DVD_W  = MAG_W + FRAC_W + 1;
  localparam int Q_W    = FRAC_W + 1;    // quotient never exceeds one

  // datapath widths
  localparam int CROSS_W = 34;           // up x w, q6.28
  localparam int COEF_W  = 34;           // hw*su and hh*sv, units 2^-28
  localparam int VB_W    = 18;           // v basis component after rounding
  localparam int RAY_W   = 50;           // unnormalized ray, units 2^-42
  localparam int SCR_W   = 16;           // screen coordinate width

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_VIEW_X   = 3'd0,
    REG_VIEW_Y   = 3'd1,
    REG_VIEW_Z   = 3'd2,
    REG_UP_X     = 3'd3,
    REG_UP_Y     = 3'd4,
    REG_UP_Z     = 3'd5,
    REG_HALF_HGT = 3'd6,
    REG_HALF_WID = 3'd7
  } cfg_idx_t;

  // per-item data carried alongside the basis
  typedef struct packed {
    logic              degenerate;
    logic [SCR_W-1:0]  screen_u;
    logic [SCR_W-1:0]  screen_v;
  } ray_side_t;

  // camera setup seen by the ray mixer
  typedef struct packed {
    logic signed [16:0] w_x;
    logic signed [16:0] w_y;
    logic signed [16:0] w_z;
    logic [15:0]        half_hgt;
    logic [15:0]        half_wid;
  } cam_cfg_t;

endpackage

[src/crd_norm3.sv]
// pipelined three-component vector normalizer to q2.14
module crd_norm3 #(
  parameter int IW  = 34,
  parameter int SBW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] in_x,
  input  logic signed [IW-1:0] in_y,
  input  logic signed [IW-1:0] in_z,
  input  logic [SBW-1:0]       in_side,
  output logic                 out_valid,
  output logic signed [15:0]   out_x,
  output logic signed [15:0]   out_y,
  output logic signed [15:0]   out_z,
  output logic                 out_zero,
  output logic [SBW-1:0]       out_side
);

  localparam int MAG_W  = crd_pkg::MAG_W;
  localparam int SQ_W   = crd_pkg::SQ_W;
  localparam int ROOT_W = crd_pkg::ROOT_W;
  localparam int SUM_W  = crd_pkg::SUM_W;
  localparam int REM_W  = crd_pkg::REM_W;
  localparam int FRAC_W = crd_pkg::FRAC_W;
  localparam int DVD_W  = crd_pkg::DVD_W;
  localparam int Q_W    = crd_pkg::Q_W;
  localparam int SH_W   = DVD_W + 1;
  localparam int NS     = $clog2(IW - MAG_W + 1);

  logic [IW-1:0] ux [3];
  assign ux[0] = in_x;
  assign ux[1] = in_y;
  assign ux[2] = in_z;

  // magnitude and pre-shift section
  logic [IW-1:0]  a_mag [NS+1][3];
  logic [2:0]     a_neg [NS+1];
  logic [SBW-1:0] a_sb  [NS+1];
  logic           a_v   [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v[0] <= 1'b0;
    end else if (en) begin
      a_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_mag[0][i] <= ux[i][IW-1] ? (~ux[i] + 1'b1) : ux[i];
        a_neg[0][i] <= ux[i][IW-1];
      end
      a_sb[0] <= in_side;
    end
  end

  // greedy binary shift until every magnitude fits below 2^MAG_W
  for (genvar j = 1; j <= NS; j++) begin : g_shift
    localparam int SH = 1 << (NS - j);
    logic [IW-1:0] ored;
    logic          take;
    assign ored = a_mag[j-1][0] | a_mag[j-1][1] | a_mag[j-1][2];
    assign take = |(ored >> (MAG_W + SH - 1));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v[j] <= 1'b0;
      end else if (en) begin
        a_v[j] <= a_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          a_mag[j][i] <= take ? (a_mag[j-1][i] >> SH) : a_mag[j-1][i];
        end
        a_neg[j] <= a_neg[j-1];
        a_sb[j]  <= a_sb[j-1];
      end
    end
  end

  // squares
  logic [SQ_W-1:0]  b_sq [3];
  logic [MAG_W-1:0] b_m  [3];
  logic [2:0]       b_neg;
  logic [SBW-1:0]   b_sb;
  logic             b_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_m[i]  <= a_mag[NS][i][MAG_W-1:0];
        b_sq[i] <= a_mag[NS][i][MAG_W-1:0] * a_mag[NS][i][MAG_W-1:0];
      end
      b_neg <= a_neg[NS];
      b_sb  <= a_sb[NS];
    end
  end

  // square root section, one result bit per stage
  logic [REM_W-1:0]  c_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] c_root [ROOT_W+1];
  logic [SUM_W-1:0]  c_n    [ROOT_W+1];
  logic [MAG_W-1:0]  c_m    [ROOT_W+1][3];
  logic [2:0]        c_neg  [ROOT_W+1];
  logic [SBW-1:0]    c_sb   [ROOT_W+1];
  logic              c_zero [ROOT_W+1];
  logic              c_v    [ROOT_W+1];

  // sum of squares enters the root pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v[0] <= 1'b0;
    end else if (en) begin
      c_v[0] <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_n[0]    <= SUM_W'(b_sq[0]) + SUM_W'(b_sq[1]) + SUM_W'(b_sq[2]);
      c_rem[0]  <= '0;
      c_root[0] <= '0;
      c_zero[0] <= ~|{b_m[0], b_m[1], b_m[2]};
      for (int i = 0; i < 3; i++) begin
        c_m[0][i] <= b_m[i];
      end
      c_neg[0] <= b_neg;
      c_sb[0]  <= b_sb;
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [REM_W+1:0] rem_t;
    logic [REM_W+1:0] trial;
    logic             ge;
    assign rem_t = {c_rem[j], c_n[j][SUM_W-1-2*j -: 2]};
    assign trial = {1'b0, c_root[j], 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v[j+1] <= 1'b0;
      end else if (en) begin
        c_v[j+1] <= c_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_rem[j+1]  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
        c_root[j+1] <= {c_root[j][ROOT_W-2:0], ge};
        c_n[j+1]    <= c_n[j];
        for (int i = 0; i < 3; i++) begin
          c_m[j+1][i] <= c_m[j][i];
        end
        c_neg[j+1]  <= c_neg[j];
        c_sb[j+1]   <= c_sb[j];
        c_zero[j+1] <= c_zero[j];
      end
    end
  end

  // division section, one quotient bit per stage
  logic [DVD_W-1:0]  d_rem  [Q_W+1][3];
  logic [Q_W-1:0]    d_q    [Q_W+1][3];
  logic [ROOT_W-1:0] d_l    [Q_W+1];
  logic [2:0]        d_neg  [Q_W+1];
  logic [SBW-1:0]    d_sb   [Q_W+1];
  logic              d_zero [Q_W+1];
  logic              d_v    [Q_W+1];

  // rounded dividend m*2^14 + len/2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v[0] <= 1'b0;
    end else if (en) begin
      d_v[0] <= c_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_rem[0][i] <= {1'b0, c_m[ROOT_W][i], {FRAC_W{1'b0}}}
                       + DVD_W'(c_root[ROOT_W] >> 1);
        d_q[0][i]   <= '0;
      end
      d_l[0]    <= c_root[ROOT_W];
      d_neg[0]  <= c_neg[ROOT_W];
      d_sb[0]   <= c_sb[ROOT_W];
      d_zero[0] <= c_zero[ROOT_W];
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int B = Q_W - 1 - j;
    logic [SH_W-1:0] sh;
    logic [2:0]      ge;
    assign sh = SH_W'(d_l[j]) << B;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = {1'b0, d_rem[j][i]} >= sh;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v[j+1] <= 1'b0;
      end else if (en) begin
        d_v[j+1] <= d_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          d_rem[j+1][i] <= ge[i] ? DVD_W'({1'b0, d_rem[j][i]} - sh) : d_rem[j][i];
          d_q[j+1][i]   <= {d_q[j][i][Q_W-2:0], ge[i]};
        end
        d_l[j+1]    <= d_l[j];
        d_neg[j+1]  <= d_neg[j];
        d_sb[j+1]   <= d_sb[j];
        d_zero[j+1] <= d_zero[j];
      end
    end
  end

  // clamp, sign and zero vector handling
  logic signed [15:0] res [3];
  always_comb begin
    logic [Q_W-1:0] qc;
    logic [15:0]    val;
    for (int i = 0; i < 3; i++) begin
      qc = (d_q[Q_W][i] > Q_W'(crd_pkg::ONE_Q14)) ? Q_W'(crd_pkg::ONE_Q14) : d_q[Q_W][i];
      val = {1'b0, qc};
      if (d_zero[Q_W]) begin
        res[i] = '0;
      end else if (d_neg[Q_W][i]) begin
        res[i] = -$signed(val);
      end else begin
        res[i] = $signed(val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= res[0];
      out_y    <= res[1];
      out_z    <= res[2];
      out_zero <= d_zero[Q_W];
      out_side <= d_sb[Q_W];
    end
  end

endmodule

[src/crd_mix.sv]
// v basis and unnormalized ray from the unit u basis and screen position
module crd_mix (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [15:0]                  in_ux,
  input  logic signed [15:0]                  in_uy,
  input  logic signed [15:0]                  in_uz,
  input  crd_pkg::ray_side_t                  in_side,
  input  crd_pkg::cam_cfg_t                   cfg,
  output logic                                out_valid,
  output logic signed [crd_pkg::RAY_W-1:0]    out_sx,
  output logic signed [crd_pkg::RAY_W-1:0]    out_sy,
  output logic signed [crd_pkg::RAY_W-1:0]    out_sz,
  output logic                                out_degenerate
);

  localparam int COEF_W = crd_pkg::COEF_W;
  localparam int VB_W   = crd_pkg::VB_W;
  localparam int RAY_W  = crd_pkg::RAY_W;
  localparam int FRAC_W = crd_pkg::FRAC_W;

  logic signed [15:0] u [3];
  logic signed [16:0] w [3];
  assign u[0] = in_ux;
  assign u[1] = in_uy;
  assign u[2] = in_uz;
  assign w[0] = cfg.w_x;
  assign w[1] = cfg.w_y;
  assign w[2] = cfg.w_z;

  // stage 0: w x u partial products and plane coefficients
  logic signed [17:0] su;
  logic signed [17:0] sv;
  logic signed [34:0] a_full;
  logic signed [34:0] b_full;
  assign su     = $signed({1'b0, in_side.screen_u, 1'b0}) - 18'sd65536;
  assign sv     = $signed({1'b0, in_side.screen_v, 1'b0}) - 18'sd65536;
  assign a_full = $signed({1'b0, cfg.half_wid}) * su;
  assign b_full = $signed({1'b0, cfg.half_hgt}) * sv;

  logic signed [32:0]       p0_r [6];
  logic signed [15:0]       u0_r [3];
  logic signed [COEF_W-1:0] a0_r, b0_r;
  logic                     deg0_r, v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r[0] <= w[1] * u[2];
      p0_r[1] <= w[2] * u[1];
      p0_r[2] <= w[2] * u[0];
      p0_r[3] <= w[0] * u[2];
      p0_r[4] <= w[0] * u[1];
      p0_r[5] <= w[1] * u[0];
      for (int i = 0; i < 3; i++) begin
        u0_r[i] <= u[i];
      end
      a0_r   <= a_full[COEF_W-1:0];
      b0_r   <= b_full[COEF_W-1:0];
      deg0_r <= in_side.degenerate;
    end
  end

  // stage 1: v = w x u rounded to q14, half away from zero
  logic signed [VB_W-1:0] vb [3];
  always_comb begin
    logic signed [33:0] d;
    logic [33:0]        mag;
    logic [33:0]        rnd;
    logic [VB_W-1:0]    r;
    for (int i = 0; i < 3; i++) begin
      d   = 34'(p0_r[2*i]) - 34'(p0_r[2*i+1]);
      mag = d[33] ? (~d + 1'b1) : d;
      rnd = (mag + 34'd8192) >> FRAC_W;
      r   = {1'b0, rnd[VB_W-2:0]};
      vb[i] = d[33] ? -$signed(r) : $signed(r);
    end
  end

  logic signed [VB_W-1:0]   v1_r [3];
  logic signed [15:0]       u1_r [3];
  logic signed [COEF_W-1:0] a1_r, b1_r;
  logic                     deg1_r, v1v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1v_r <= 1'b0;
    end else if (en) begin
      v1v_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_r[i] <= vb[i];
        u1_r[i] <= u0_r[i];
      end
      a1_r   <= a0_r;
      b1_r   <= b0_r;
      deg1_r <= deg0_r;
    end
  end

  // stage 2: coefficient times basis
  logic signed [49:0] pa_full [3];
  logic signed [51:0] pb_full [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_full[i] = a1_r * u1_r[i];
      pb_full[i] = b1_r * v1_r[i];
    end
  end

  logic signed [RAY_W-1:0] pa2_r [3];
  logic signed [RAY_W-1:0] pb2_r [3];
  logic                    deg2_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa2_r[i] <= RAY_W'(pa_full[i]);
        pb2_r[i] <= pb_full[i][RAY_W-1:0];
      end
      deg2_r <= deg1_r;
    end
  end

  // stage 3: sum and subtract w scaled to 2^-42
  logic signed [RAY_W-1:0] s [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i] = pa2_r[i] + pb2_r[i] - (RAY_W'(w[i]) <<< 28);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sx         <= s[0];
      out_sy         <= s[1];
      out_sz         <= s[2];
      out_degenerate <= deg2_r;
    end
  end

endmodule

[src/camera_ray_direction_unit.sv]
// top level: pinhole camera ray direction pipeline
// one item accepted per cycle while no result is held by out_stall
// the whole pipeline holds while a result waits under out_stall
// synchronous active-low reset clears all valid bits and loads register defaults
// the basis is rebuilt per item from the live registers, no warm-up after writes
module camera_ray_direction_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_screen_u,
  input  logic [15:0]        in_screen_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_ray_dir_x,
  output logic signed [15:0] out_ray_dir_y,
  output logic signed [15:0] out_ray_dir_z,
  output logic               out_basis_degenerate,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CROSS_W = crd_pkg::CROSS_W;
  localparam int RAY_W   = crd_pkg::RAY_W;
  localparam int SCR_W   = crd_pkg::SCR_W;

  // configuration registers
  logic signed [15:0] view_r [3];
  logic signed [15:0] up_r   [3];
  logic [15:0]        half_hgt_r, half_wid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r[0]  <= 16'sd0;
      view_r[1]  <= 16'sd0;
      view_r[2]  <= -16'sd16384;
      up_r[0]    <= 16'sd0;
      up_r[1]    <= 16'sd16384;
      up_r[2]    <= 16'sd0;
      half_hgt_r <= 16'd4096;
      half_wid_r <= 16'd4096;
    end else if (cfg_we) begin
      unique case (crd_pkg::cfg_idx_t'(cfg_index))
        crd_pkg::REG_VIEW_X:   view_r[0]  <= cfg_data;
        crd_pkg::REG_VIEW_Y:   view_r[1]  <= cfg_data;
        crd_pkg::REG_VIEW_Z:   view_r[2]  <= cfg_data;
        crd_pkg::REG_UP_X:     up_r[0]    <= cfg_data;
        crd_pkg::REG_UP_Y:     up_r[1]    <= cfg_data;
        crd_pkg::REG_UP_Z:     up_r[2]    <= cfg_data;
        crd_pkg::REG_HALF_HGT: half_hgt_r <= cfg_data;
        crd_pkg::REG_HALF_WID: half_wid_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // w = -view
  logic signed [16:0] w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = -(17'(view_r[i]));
    end
  end

  crd_pkg::cam_cfg_t cam;
  assign cam.w_x      = w[0];
  assign cam.w_y      = w[1];
  assign cam.w_z      = w[2];
  assign cam.half_hgt = half_hgt_r;
  assign cam.half_wid = half_wid_r;

  // stage: c = up x w
  logic signed [CROSS_W-1:0] c_r [3];
  logic [SCR_W-1:0]          cu_r, cv_r;
  logic                      c_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0] <= CROSS_W'(up_r[1] * w[2]) - CROSS_W'(up_r[2] * w[1]);
      c_r[1] <= CROSS_W'(up_r[2] * w[0]) - CROSS_W'(up_r[0] * w[2]);
      c_r[2] <= CROSS_W'(up_r[0] * w[1]) - CROSS_W'(up_r[1] * w[0]);
      cu_r   <= in_screen_u;
      cv_r   <= in_screen_v;
    end
  end

  // u basis
  logic                   n1_valid, n1_zero;
  logic signed [15:0]     n1_x, n1_y, n1_z;
  logic [2*SCR_W-1:0]     n1_side;

  crd_norm3 #(
    .IW  (CROSS_W),
    .SBW (2 * SCR_W)
  ) u_norm_basis (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (c_v_r),
    .in_x      (c_r[0]),
    .in_y      (c_r[1]),
    .in_z      (c_r[2]),
    .in_side   ({cu_r, cv_r}),
    .out_valid (n1_valid),
    .out_x     (n1_x),
    .out_y     (n1_y),
    .out_z     (n1_z),
    .out_zero  (n1_zero),
    .out_side  (n1_side)
  );

  crd_pkg::ray_side_t mix_side;
  assign mix_side.degenerate = n1_zero;
  assign mix_side.screen_u   = n1_side[2*SCR_W-1:SCR_W];
  assign mix_side.screen_v   = n1_side[SCR_W-1:0];

  // v basis and unnormalized ray
  logic                    mx_valid, mx_deg;
  logic signed [RAY_W-1:0] mx_x, mx_y, mx_z;

  crd_mix u_mix (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (adv),
    .in_valid       (n1_valid),
    .in_ux          (n1_x),
    .in_uy          (n1_y),
    .in_uz          (n1_z),
    .in_side        (mix_side),
    .cfg            (cam),
    .out_valid      (mx_valid),
    .out_sx         (mx_x),
    .out_sy         (mx_y),
    .out_sz         (mx_z),
    .out_degenerate (mx_deg)
  );

  // ray normalization
  logic               n2_zero, n2_deg;
  logic signed [15:0] n2_x, n2_y, n2_z;

  crd_norm3 #(
    .IW  (RAY_W),
    .SBW (1)
  ) u_norm_ray (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (mx_valid),
    .in_x      (mx_x),
    .in_y      (mx_y),
    .in_z      (mx_z),
    .in_side   (mx_deg),
    .out_valid (out_valid),
    .out_x     (n2_x),
    .out_y     (n2_y),
    .out_z     (n2_z),
    .out_zero  (n2_zero),
    .out_side  (n2_deg)
  );

  // degenerate basis or zero ray forces a zero direction
  assign out_ray_dir_x        = (n2_deg || n2_zero) ? 16'sd0 : n2_x;
  assign out_ray_dir_y        = (n2_deg || n2_zero) ? 16'sd0 : n2_y;
  assign out_ray_dir_z        = (n2_deg || n2_zero) ? 16'sd0 : n2_z;
  assign out_basis_degenerate = n2_deg;

endmodule
